// ===== rtl/form_variable_extractor_assert.svh =====
// Assertion macros for the form variable extractor.
`ifndef FORM_VARIABLE_EXTRACTOR_ASSERT_SVH
`define FORM_VARIABLE_EXTRACTOR_ASSERT_SVH

`ifndef SYNTHESIS
`define FVE_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("form_variable_extractor: check failed");
`define FVE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("form_variable_extractor: check failed");
`else
`define FVE_ASSERT_SAME(label, ante, cons)
`define FVE_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== rtl/fve_pkg.sv =====
// Shared types, character constants and helper functions.
package fve_pkg;

    localparam logic [7:0] CH_NUL  = 8'h00;
    localparam logic [7:0] CH_PCT  = 8'h25;
    localparam logic [7:0] CH_AMP  = 8'h26;
    localparam logic [7:0] CH_EQ   = 8'h3D;
    localparam logic [7:0] CH_DASH = 8'h2D;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_A    = 8'h61;

    localparam logic [2:0] PATTERN_LEN = 3'd7;
    localparam int         QUEUE_DEPTH = 4;

    typedef struct packed {
        logic        is_end;
        logic        is_amp;
        logic        is_pct;
        logic        is_eq;
        logic [3:0]  hex;
        logic [7:0]  data;
        logic        found;
        logic [11:0] pos;
    } t_cmd;

    function automatic logic [7:0] pattern_char(input logic [2:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0:    ch = 8'h61;
            3'd1:    ch = 8'h63;
            3'd2:    ch = 8'h74;
            3'd3:    ch = 8'h69;
            3'd4:    ch = 8'h6F;
            3'd5:    ch = 8'h6E;
            default: ch = CH_EQ;
        endcase
        return ch;
    endfunction

    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [7:0] v;
        v = 8'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = c - 8'h30;
        end else if (c >= 8'h61 && c <= 8'h66) begin
            v = c - 8'h57;
        end else if (c >= 8'h41 && c <= 8'h46) begin
            v = c - 8'h37;
        end
        return v[3:0];
    endfunction

endpackage

// ===== rtl/fve_queue.sv =====
// Small FIFO of classified words between the front and back parts.
module fve_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr,
    input  fve_pkg::t_cmd i_wdata,
    output logic          o_full,
    input  logic          i_rd,
    output fve_pkg::t_cmd o_rdata,
    output logic          o_empty
);
    import fve_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);

    t_cmd                r_mem [QUEUE_DEPTH];
    logic [AW-1:0]       r_wr_ptr;
    logic [AW-1:0]       r_rd_ptr;
    logic [AW:0]         r_count;
    logic [AW-1:0]       n_wr_ptr;
    logic [AW-1:0]       n_rd_ptr;
    logic [AW:0]         n_count;
    logic                wr_en;
    logic                rd_en;

    assign o_full  = (r_count == (AW+1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign wr_en   = i_wr && !o_full;
    assign rd_en   = i_rd && !o_empty;
    assign o_rdata = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (wr_en) begin
            n_wr_ptr = r_wr_ptr + 1'b1;
        end
        if (rd_en) begin
            n_rd_ptr = r_rd_ptr + 1'b1;
        end
        if (wr_en && !rd_en) begin
            n_count = r_count + 1'b1;
        end else if (rd_en && !wr_en) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

`include "form_variable_extractor_assert.svh"
    `FVE_ASSERT_SAME(a_count_bound, 1'b1, r_count <= (AW+1)'(QUEUE_DEPTH))

endmodule

// ===== rtl/fve_front.sv =====
// Front part: tracks position, searches for action= and classifies each byte.
module fve_front #(
    parameter int SCAN_LIMIT = 2048
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic [7:0]    i_byte,
    output logic          o_wr,
    output fve_pkg::t_cmd o_cmd
);
    import fve_pkg::*;

    localparam int PW = $clog2(SCAN_LIMIT + 1);
    localparam logic [PW-1:0] LIMIT = PW'(SCAN_LIMIT);

    logic          r_found;
    logic [2:0]    r_match_count;
    logic [PW-1:0] r_pos;
    logic [PW-1:0] r_match_start;
    logic          n_found;
    logic [2:0]    n_match_count;
    logic [PW-1:0] n_pos;
    logic [PW-1:0] n_match_start;
    logic          is_end;
    logic          hit;

    assign is_end = (i_byte == CH_NUL);
    assign hit    = (r_match_count < PATTERN_LEN) && (i_byte == pattern_char(r_match_count));

    always_comb begin
        n_found       = r_found;
        n_match_count = r_match_count;
        n_pos         = r_pos;
        n_match_start = r_match_start;
        if (i_accept) begin
            if (r_pos < LIMIT) begin
                n_pos = r_pos + 1'b1;
            end
            if (is_end) begin
                n_found       = 1'b0;
                n_match_count = '0;
                n_pos         = '0;
                n_match_start = '0;
            end else if (!r_found) begin
                if (hit) begin
                    if (r_match_count == 3'd0) begin
                        n_match_start = r_pos;
                    end
                    n_match_count = r_match_count + 1'b1;
                end else if (i_byte == CH_A) begin
                    n_match_start = r_pos;
                    n_match_count = 3'd1;
                end else begin
                    n_match_count = '0;
                end
                if (n_match_count == PATTERN_LEN) begin
                    n_match_count = '0;
                    if (n_match_start < LIMIT) begin
                        n_found = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found       <= 1'b0;
            r_match_count <= '0;
            r_pos         <= '0;
            r_match_start <= '0;
        end else begin
            r_found       <= n_found;
            r_match_count <= n_match_count;
            r_pos         <= n_pos;
            r_match_start <= n_match_start;
        end
    end

    // bytes seen before the match produce nothing and are not queued
    assign o_wr = i_accept && (is_end || r_found);

    always_comb begin
        o_cmd.is_end = is_end;
        o_cmd.is_amp = (i_byte == CH_AMP);
        o_cmd.is_pct = (i_byte == CH_PCT);
        o_cmd.is_eq  = (i_byte == CH_EQ);
        o_cmd.hex    = hex_value(i_byte);
        o_cmd.data   = i_byte;
        o_cmd.found  = r_found;
        o_cmd.pos    = r_found ? 12'(r_match_start) : 12'(SCAN_LIMIT);
    end

`include "form_variable_extractor_assert.svh"
    `FVE_ASSERT_SAME(a_found_no_partial, r_found, r_match_count == 3'd0)
    `FVE_ASSERT_SAME(a_pos_saturates, 1'b1, r_pos <= LIMIT)

endmodule

// ===== rtl/fve_back.sv =====
// Back part: key/value/escape decoding and the output register.
module fve_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  fve_pkg::t_cmd i_cmd,
    input  logic          i_cmd_valid,
    output logic          o_cmd_rd,
    input  logic          i_pop,
    output logic          o_empty,
    output logic [7:0]    o_out_byte,
    output logic          o_byte_valid,
    output logic          o_last,
    output logic          o_found,
    output logic [11:0]   o_match_position
);
    import fve_pkg::*;

    localparam logic [1:0] MODE_VALUE = 2'd0;
    localparam logic [1:0] MODE_KEY   = 2'd1;
    localparam logic [1:0] MODE_PCT1  = 2'd2;
    localparam logic [1:0] MODE_PCT2  = 2'd3;

    logic [1:0]  r_mode;
    logic [3:0]  r_high;
    logic        r_out_valid;
    logic [7:0]  r_byte;
    logic        r_bvalid;
    logic        r_last;
    logic        r_found;
    logic [11:0] r_pos;
    logic [1:0]  n_mode;
    logic [3:0]  n_high;
    logic        n_out_valid;
    logic        emit;
    logic [7:0]  emit_byte;
    logic        emit_bvalid;
    logic        ready;
    logic        take;

    assign ready    = !r_out_valid || i_pop;
    assign take     = i_cmd_valid && ready;
    assign o_cmd_rd = take;

    always_comb begin
        n_mode      = r_mode;
        n_high      = r_high;
        emit        = 1'b0;
        emit_byte   = i_cmd.data;
        emit_bvalid = 1'b1;
        if (i_cmd.is_end) begin
            emit        = 1'b1;
            emit_byte   = i_cmd.found ? CH_LF : CH_NUL;
            emit_bvalid = i_cmd.found;
            n_mode      = MODE_VALUE;
            n_high      = '0;
        end else begin
            case (r_mode)
                MODE_KEY: begin
                    if (i_cmd.is_eq) begin
                        n_mode = MODE_VALUE;
                    end
                end
                MODE_VALUE: begin
                    if (i_cmd.is_amp) begin
                        n_mode    = MODE_KEY;
                        emit      = 1'b1;
                        emit_byte = CH_DASH;
                    end else if (i_cmd.is_pct) begin
                        n_mode = MODE_PCT1;
                    end else begin
                        emit = 1'b1;
                    end
                end
                MODE_PCT1: begin
                    n_high = i_cmd.hex;
                    n_mode = MODE_PCT2;
                end
                MODE_PCT2: begin
                    n_mode    = MODE_VALUE;
                    emit      = 1'b1;
                    emit_byte = {r_high, i_cmd.hex};
                end
                default: begin
                    n_mode = MODE_VALUE;
                end
            endcase
        end
        if (!take) begin
            n_mode = r_mode;
            n_high = r_high;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (take) begin
            n_out_valid = emit;
        end else if (i_pop) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_VALUE;
            r_high      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_mode      <= n_mode;
            r_high      <= n_high;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && emit) begin
            r_byte   <= emit_byte;
            r_bvalid <= emit_bvalid;
            r_last   <= i_cmd.is_end;
            r_found  <= i_cmd.found;
            r_pos    <= i_cmd.pos;
        end
    end

    assign o_empty          = !r_out_valid;
    assign o_out_byte       = r_byte;
    assign o_byte_valid     = r_bvalid;
    assign o_last           = r_last;
    assign o_found          = r_found;
    assign o_match_position = r_pos;

`include "form_variable_extractor_assert.svh"
    `FVE_ASSERT_NEXT(a_pct1_to_pct2, take && !i_cmd.is_end && r_mode == MODE_PCT1,
        r_mode == MODE_PCT2)
    `FVE_ASSERT_SAME(a_end_valid_found, r_out_valid && r_last, r_bvalid == r_found)

endmodule

// ===== rtl/form_variable_extractor.sv =====
// Top level of the form variable extractor.
//
// Input channel: present a request byte on i_in_byte and raise push; the
// byte is taken at an edge where push is high and full is low. A zero
// byte ends the message. Result channel: while empty is low the oldest
// result sits on the o_* payload ports; it is taken at an edge where pop
// is high. Results are decoded value bytes, '-' for each '&' that ends a
// value, and one final word with o_last set for the zero byte, carrying
// o_found and o_match_position.
// Throughput: one byte per cycle while full is low. A byte that yields a
// result passes the front classifier, the four-word queue and the back
// decoder with its output register on its way to the result ports. Bytes
// before the match produce nothing.
// When pop is held low the output register and the queue fill; full then
// rises and input stalls until words are drained.
// Reset (synchronous, active low) empties the queue and output register
// and returns the parser to its search state at position zero.
module form_variable_extractor #(
    parameter int SCAN_LIMIT = 2048
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_in_byte,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_out_byte,
    output logic        o_byte_valid,
    output logic        o_last,
    output logic        o_found,
    output logic [11:0] o_match_position
);
    import fve_pkg::*;

    logic accept;
    logic q_wr;
    logic q_full;
    logic q_empty;
    logic q_rd;
    t_cmd q_wdata;
    t_cmd q_rdata;

    assign full   = q_full;
    assign accept = push && !q_full;

    fve_front #(
        .SCAN_LIMIT (SCAN_LIMIT)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (i_in_byte),
        .o_wr     (q_wr),
        .o_cmd    (q_wdata)
    );

    fve_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_wdata (q_wdata),
        .o_full  (q_full),
        .i_rd    (q_rd),
        .o_rdata (q_rdata),
        .o_empty (q_empty)
    );

    fve_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (q_rdata),
        .i_cmd_valid      (!q_empty),
        .o_cmd_rd         (q_rd),
        .i_pop            (pop),
        .o_empty          (empty),
        .o_out_byte       (o_out_byte),
        .o_byte_valid     (o_byte_valid),
        .o_last           (o_last),
        .o_found          (o_found),
        .o_match_position (o_match_position)
    );

endmodule
